/* sv/trailing_reference_signal_core_assert.svh */
// ---------------------------------------------------------------------------
// trailing reference signal core assertion macros
// shared property wrappers for the port checker
// ---------------------------------------------------------------------------
`ifndef TRAILING_REFERENCE_SIGNAL_CORE_ASSERT_SVH
`define TRAILING_REFERENCE_SIGNAL_CORE_ASSERT_SVH

// checked only while out of reset
`define TRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define TRS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* sv/trs_pkg.sv */
// ---------------------------------------------------------------------------
// trs_pkg
// types and constants shared by the trailing reference signal core
// ---------------------------------------------------------------------------
package trs_pkg;

    localparam int PRICE_W   = 32;
    localparam int LVL_W     = 31;
    localparam int CFG_W     = 16;
    localparam int FRAC_W    = 16;
    localparam int WGT_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_O_W = 56;

    localparam int MUL_A_W   = 47;
    localparam int MUL_B_W   = 17;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    localparam int DIV_Q_W   = WGT_W;
    localparam int DIV_PRE_W = DIV_Q_W - FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

    localparam logic [CFG_W-1:0]   K_095     = 16'd62259;
    localparam logic [MUL_B_W-1:0] Q_ONE     = 17'h10000;
    localparam logic [CFG_W-1:0]   CFG_RST   = 16'd3277;
    localparam logic [LVL_W-1:0]   MAX_LVL   = {LVL_W{1'b1}};
    localparam logic [WGT_W-1:0]   MAX_WGT   = {WGT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_BUY_BAND  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUY_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SELL_BAND = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SELL_STEP = 2'd3;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_BUY,
        KIND_SELL
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_INIT1,
        S_INIT2,
        S_MOVE,
        S_CHECK,
        S_DIV,
        S_SELL,
        S_BUY,
        S_DONE
    } t_state;

endpackage

/* sv/trailing_reference_signal_core.sv */
// ---------------------------------------------------------------------------
// trailing_reference_signal_core
// trailing reference buy/sell signal generator, one result beat per price
// a missing price goes straight to the output; otherwise the result takes
// one or two bit-serial multiplies, plus a divide on a buy that does not saturate
// one price at a time, held off by any output stall; the next beat is taken
// once the result is in the output register
// reset: synchronous active low, clears state and loads band/step defaults
// ---------------------------------------------------------------------------
module trailing_reference_signal_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [trs_pkg::PRICE_W-1:0]     s_axis_tdata,   // price
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [trs_pkg::TDATA_O_W-1:0]   m_axis_tdata,   // buy_weight, current_reference
    output logic [1:0]                      m_axis_tuser,   // signal_kind
    input  logic                            i_cfg_we,
    input  logic [trs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [trs_pkg::CFG_W-1:0]       i_cfg_data
);
    import trs_pkg::*;

    t_state             r_state, n_state;
    logic [PRICE_W-1:0] r_price, n_price;
    logic               r_started, n_started;
    logic               r_holding, n_holding;
    logic               r_up, n_up;
    logic [LVL_W-1:0]   r_ref, n_ref;
    logic [LVL_W-1:0]   r_ext, n_ext;
    t_kind              r_kind, n_kind;
    logic [WGT_W-1:0]   r_weight, n_weight;
    logic [CFG_W-1:0]   r_buy_band, n_buy_band;
    logic [CFG_W-1:0]   r_buy_step, n_buy_step;
    logic [CFG_W-1:0]   r_sell_band, n_sell_band;
    logic [CFG_W-1:0]   r_sell_step, n_sell_step;
    logic               r_m_valid, n_m_valid;
    t_kind              r_m_kind, n_m_kind;
    logic [WGT_W-1:0]   r_m_weight, n_m_weight;
    logic [LVL_W-1:0]   r_m_ref, n_m_ref;

    logic               mul_start, mul_done;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_prod;
    logic               div_start, div_done;
    logic [DIV_Q_W-1:0] div_quot;

    logic               price_ok;
    logic [LVL_W-1:0]   p31;
    logic               p_ge_r;
    logic [LVL_W-1:0]   abs_gap;
    logic [LVL_W-1:0]   excess;
    logic               wgt_sat;
    logic [LVL_W-1:0]   move_d;
    logic [LVL_W:0]     sell_t;
    logic [LVL_W-1:0]   sell_ref;

    trs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    trs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (excess),
        .i_den   (r_ref),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        p31      = r_price[LVL_W-1:0];
        price_ok = !r_price[PRICE_W-1] && (r_price != '0);
        p_ge_r   = p31 >= r_ref;
        abs_gap  = p_ge_r ? (p31 - r_ref) : (r_ref - p31);
        excess   = p31 - r_ref;
        wgt_sat  = {{DIV_PRE_W{1'b0}}, excess} >= {r_ref, {DIV_PRE_W{1'b0}}};
        move_d   = mul_prod[FRAC_W+LVL_W-1:FRAC_W];
        sell_t   = mul_prod[FRAC_W+LVL_W:FRAC_W];
        sell_ref = sell_t[LVL_W] ? MAX_LVL : sell_t[LVL_W-1:0];

        n_state     = r_state;
        n_price     = r_price;
        n_started   = r_started;
        n_holding   = r_holding;
        n_up        = r_up;
        n_ref       = r_ref;
        n_ext       = r_ext;
        n_kind      = r_kind;
        n_weight    = r_weight;
        n_buy_band  = r_buy_band;
        n_buy_step  = r_buy_step;
        n_sell_band = r_sell_band;
        n_sell_step = r_sell_step;
        n_m_valid   = r_m_valid && !m_axis_tready;
        n_m_kind    = r_m_kind;
        n_m_weight  = r_m_weight;
        n_m_ref     = r_m_ref;
        mul_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BUY_BAND:  n_buy_band  = i_cfg_data;
                REG_BUY_STEP:  n_buy_step  = i_cfg_data;
                REG_SELL_BAND: n_sell_band = i_cfg_data;
                REG_SELL_STEP: n_sell_step = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_price = s_axis_tdata;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_kind   = KIND_NONE;
                n_weight = '0;
                if (!price_ok) begin
                    n_state = S_DONE;
                end else if (!r_started) begin
                    mul_start = 1'b1;
                    mul_a     = MUL_A_W'(p31);
                    mul_b     = MUL_B_W'(K_095);
                    n_state   = S_INIT1;
                end else begin
                    mul_start = 1'b1;
                    mul_a     = MUL_A_W'(abs_gap);
                    mul_b     = MUL_B_W'(r_holding ? r_sell_step : r_buy_step);
                    n_up      = p_ge_r;
                    n_state   = S_MOVE;
                end
            end
            S_INIT1: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = mul_prod[MUL_A_W-1:0];
                    mul_b     = Q_ONE - MUL_B_W'(r_sell_band);
                    n_state   = S_INIT2;
                end
            end
            S_INIT2: begin
                if (mul_done) begin
                    n_ref     = mul_prod[2*PRICE_W-2:PRICE_W];
                    n_ext     = p31;
                    n_holding = 1'b1;
                    n_started = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_MOVE: begin
                if (mul_done) begin
                    n_ref   = r_up ? (r_ref + move_d) : (r_ref - move_d);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_holding) begin
                    if (p31 <= r_ref) begin
                        mul_start = 1'b1;
                        mul_a     = MUL_A_W'(r_ext);
                        mul_b     = Q_ONE + MUL_B_W'(r_buy_band);
                        n_state   = S_SELL;
                    end else begin
                        if (p31 > r_ext) begin
                            n_ext = p31;
                        end
                        n_state = S_DONE;
                    end
                end else begin
                    if (p_ge_r) begin
                        if (wgt_sat) begin
                            n_weight  = MAX_WGT;
                            mul_start = 1'b1;
                            mul_a     = MUL_A_W'(r_ext);
                            mul_b     = Q_ONE - MUL_B_W'(r_sell_band);
                            n_state   = S_BUY;
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end else begin
                        if (p31 < r_ext) begin
                            n_ext = p31;
                        end
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_weight  = div_quot;
                    mul_start = 1'b1;
                    mul_a     = MUL_A_W'(r_ext);
                    mul_b     = Q_ONE - MUL_B_W'(r_sell_band);
                    n_state   = S_BUY;
                end
            end
            S_SELL: begin
                if (mul_done) begin
                    n_ref     = sell_ref;
                    n_ext     = p31;
                    n_holding = 1'b0;
                    n_kind    = KIND_SELL;
                    n_state   = S_DONE;
                end
            end
            S_BUY: begin
                if (mul_done) begin
                    n_ref     = move_d;
                    n_ext     = p31;
                    n_holding = 1'b1;
                    n_kind    = KIND_BUY;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_kind   = r_kind;
                    n_m_weight = r_weight;
                    n_m_ref    = r_ref;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_holding   <= 1'b0;
            r_ref       <= '0;
            r_ext       <= '0;
            r_buy_band  <= CFG_RST;
            r_buy_step  <= CFG_RST;
            r_sell_band <= CFG_RST;
            r_sell_step <= CFG_RST;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_holding   <= n_holding;
            r_ref       <= n_ref;
            r_ext       <= n_ext;
            r_buy_band  <= n_buy_band;
            r_buy_step  <= n_buy_step;
            r_sell_band <= n_sell_band;
            r_sell_step <= n_sell_step;
            r_m_valid   <= n_m_valid;
        end
        r_price    <= n_price;
        r_up       <= n_up;
        r_kind     <= n_kind;
        r_weight   <= n_weight;
        r_m_kind   <= n_m_kind;
        r_m_weight <= n_m_weight;
        r_m_ref    <= n_m_ref;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(TDATA_O_W - WGT_W - LVL_W){1'b0}}, r_m_ref, r_m_weight};
    assign m_axis_tuser  = r_m_kind;

endmodule

/* sv/trs_mul.sv */
// ---------------------------------------------------------------------------
// trs_mul
// shift-add multiplier, one multiplier bit per cycle, lsb first
// ---------------------------------------------------------------------------
module trs_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [trs_pkg::MUL_A_W-1:0] i_a,
    input  logic [trs_pkg::MUL_B_W-1:0] i_b,
    output logic                         o_done,
    output logic [trs_pkg::MUL_P_W-1:0] o_prod
);
    import trs_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [MUL_CNT_W-1:0] r_cnt, n_cnt;
    logic [MUL_A_W-1:0]   r_a, n_a;
    logic [MUL_B_W-1:0]   r_b, n_b;
    logic [MUL_P_W-1:0]   r_acc, n_acc;
    logic [MUL_A_W:0]     sum;

    always_comb begin
        sum    = {1'b0, r_acc[MUL_P_W-1:MUL_B_W]} + (r_b[0] ? {1'b0, r_a} : '0);
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = MUL_CNT_W'(MUL_B_W);
            n_a    = i_a;
            n_b    = i_b;
            n_acc  = '0;
        end else if (r_busy) begin
            n_acc = {sum, r_acc[MUL_B_W-1:1]};
            n_b   = r_b >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == MUL_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* sv/trs_div.sv */
// ---------------------------------------------------------------------------
// trs_div
// restoring divider for the buy weight, one quotient bit per cycle
// ---------------------------------------------------------------------------
module trs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [trs_pkg::LVL_W-1:0]   i_num,
    input  logic [trs_pkg::LVL_W-1:0]   i_den,
    output logic                        o_done,
    output logic [trs_pkg::DIV_Q_W-1:0] o_quot
);
    import trs_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [LVL_W-1:0]     r_rem, n_rem;
    logic [LVL_W-1:0]     r_den, n_den;
    logic [DIV_Q_W-1:0]   r_lo, n_lo;
    logic [DIV_Q_W-1:0]   r_q, n_q;
    logic [LVL_W:0]       trial;
    logic [LVL_W:0]       diff;
    logic                 ge;

    always_comb begin
        trial  = {r_rem, r_lo[DIV_Q_W-1]};
        diff   = trial - {1'b0, r_den};
        ge     = trial >= {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_lo   = r_lo;
        n_q    = r_q;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_Q_W);
            n_rem  = {{DIV_PRE_W{1'b0}}, i_num[LVL_W-1:DIV_PRE_W]};
            n_lo   = {i_num[DIV_PRE_W-1:0], {FRAC_W{1'b0}}};
            n_den  = i_den;
            n_q    = '0;
        end else if (r_busy) begin
            n_rem = ge ? diff[LVL_W-1:0] : trial[LVL_W-1:0];
            n_lo  = r_lo << 1;
            n_q   = {r_q[DIV_Q_W-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_lo  <= n_lo;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* sv/trs_chk.sv */
// ---------------------------------------------------------------------------
// trs_chk
// port-level checker for the trailing reference signal core
// ---------------------------------------------------------------------------
`include "trailing_reference_signal_core_assert.svh"

module trs_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [trs_pkg::PRICE_W-1:0]     s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [trs_pkg::TDATA_O_W-1:0]   m_axis_tdata,
    input logic [1:0]                      m_axis_tuser,
    input logic                            i_cfg_we,
    input logic [trs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input logic [trs_pkg::CFG_W-1:0]       i_cfg_data
);
    import trs_pkg::*;

    `TRS_ASSERT_RST(a_rst_clears_out, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")
    `TRS_ASSERT(a_busy_after_in, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "took a beat while busy")
    `TRS_ASSERT(a_wgt_only_buy, m_axis_tvalid && (m_axis_tuser != KIND_BUY) |-> (m_axis_tdata[WGT_W-1:0] == '0), "weight without buy")
    `TRS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled beat changed")

endmodule

bind trailing_reference_signal_core trs_chk u_trs_chk (.*);
